// File: design/sliding_window_slot_reconciler_core_defines.svh
// Assertion helpers, clocked on clock, off during reset.
`ifndef SLIDING_WINDOW_SLOT_RECONCILER_CORE_DEFINES_SVH
`define SLIDING_WINDOW_SLOT_RECONCILER_CORE_DEFINES_SVH

`define SWSR_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("check failed");

`define SWSR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("check failed");

`endif

// File: design/swsr_pkg.sv
`default_nettype none
package swsr_pkg;
   localparam int DEF_VIEW_RADIUS = 2;
   localparam int DEF_COORD_WIDTH = 16;
   localparam int TILE_W          = 16;
   localparam int SLOT_IDX_W      = 6;

   localparam logic CMD_LOAD    = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_LOAD,
      ST_RELEASE,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic                    command;
      logic [SLOT_IDX_W-1:0]   slot_index;
      logic [TILE_W-1:0]       tile_x;
      logic [TILE_W-1:0]       tile_y;
      logic [TILE_W-1:0]       tile_z;
   } cmd_type;

   typedef struct packed {
      logic push;
      logic finish;
   } buf_ctrl_type;
endpackage
`default_nettype wire

// File: design/swsr_req_if.sv
`default_nettype none
interface swsr_req_if
   import swsr_pkg::*;
   ();
   logic                     valid;
   logic                     ready;
   logic signed [TILE_W-1:0] center_x;
   logic signed [TILE_W-1:0] center_y;
   logic signed [TILE_W-1:0] center_z;

   modport source (output valid, output center_x, output center_y, output center_z,
                   input ready);
   modport sink (input valid, input center_x, input center_y, input center_z,
                 output ready);
endinterface
`default_nettype wire

// File: design/swsr_rsp_if.sv
`default_nettype none
interface swsr_rsp_if
   import swsr_pkg::*;
   ();
   logic                     valid;
   logic                     ready;
   logic                     command;
   logic [SLOT_IDX_W-1:0]    slot_index;
   logic signed [TILE_W-1:0] tile_x;
   logic signed [TILE_W-1:0] tile_y;
   logic signed [TILE_W-1:0] tile_z;
   logic                     last;

   modport source (output valid, output command, output slot_index, output tile_x,
                   output tile_y, output tile_z, output last, input ready);
   modport sink (input valid, input command, input slot_index, input tile_x,
                 input tile_y, input tile_z, input last, output ready);
endinterface
`default_nettype wire

// File: design/sliding_window_slot_reconciler_core.sv
// Keeps 2^(3*clog2(2*VIEW_RADIUS)) slots of tile coordinates in one synchronous tile memory
// and, for each new window centre word, emits load words for window tiles no slot holds and
// release words for slots left over, the final word of a centre marked last. A centre is
// accepted, then the memory is scanned (one slot read per cycle), then the window positions
// and the slot pointer are walked (one step per cycle, a word step waiting while the output
// cannot take it), then the block changes phase and closes; output stalls hold the close. A new
// centre is taken only when idle.
`default_nettype none
`include "sliding_window_slot_reconciler_core_defines.svh"
module sliding_window_slot_reconciler_core
   import swsr_pkg::*;
#(
   parameter int VIEW_RADIUS = DEF_VIEW_RADIUS,
   parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
   input wire logic   clock,
   input wire logic   reset,
   swsr_req_if.sink   req_chan,
   swsr_rsp_if.source rsp_chan
);
   localparam int LB    = $clog2(2 * VIEW_RADIUS);
   localparam int SW    = 3 * LB;
   localparam int NSLOT = 1 << SW;
   localparam int W     = COORD_WIDTH;
   localparam int DW    = 3 * W;

   state_type     state_ff, state_in;
   logic [SW:0]   idx_ff, idx_in;
   logic [SW:0]   j_ff, j_in;
   logic [SW:0]   p_ff, p_in;
   logic          rd_valid_ff, rd_valid_in;
   logic [SW-1:0] rd_slot_ff, rd_slot_in;
   logic [NSLOT-1:0] used_ff, used_in;
   logic [NSLOT-1:0] free_ff, free_in;
   logic [NSLOT-1:0] present_ff, present_in;
   logic [W-1:0]  base_x_ff, base_x_in, base_y_ff, base_y_in, base_z_ff, base_z_in;

   logic [31:0]   ext_x, ext_y, ext_z;
   logic [W-1:0]  tx, ty, tz, offx, offy, offz;
   logic [DW-1:0] rd_data;
   logic          rd_en, wr_en, in_win, can_take;
   logic [SW-1:0] hit_j;
   buf_ctrl_type  bctl;
   cmd_type       cmd;

   swsr_tile_mem #(.DEPTH(NSLOT), .AW(SW), .DW(DW)) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (p_ff[SW-1:0]),
      .wr_data ({tx, ty, tz}),
      .rd_en   (rd_en),
      .rd_addr (idx_ff[SW-1:0]),
      .rd_data (rd_data)
   );

   swsr_rsp_buf u_buf (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (bctl),
      .cmd      (cmd),
      .can_take (can_take),
      .rsp_chan (rsp_chan)
   );

   always_comb begin
      ext_x  = {{16{req_chan.center_x[15]}}, req_chan.center_x};
      ext_y  = {{16{req_chan.center_y[15]}}, req_chan.center_y};
      ext_z  = {{16{req_chan.center_z[15]}}, req_chan.center_z};
      tx     = base_x_ff + W'(j_ff[3*LB-1:2*LB]);
      ty     = base_y_ff + W'(j_ff[2*LB-1:LB]);
      tz     = base_z_ff + W'(j_ff[LB-1:0]);
      offx   = rd_data[DW-1:2*W] - base_x_ff;
      offy   = rd_data[2*W-1:W] - base_y_ff;
      offz   = rd_data[W-1:0] - base_z_ff;
      in_win = (offx[W-1:LB] == '0) && (offy[W-1:LB] == '0) && (offz[W-1:LB] == '0);
      hit_j  = {offx[LB-1:0], offy[LB-1:0], offz[LB-1:0]};
   end

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      j_in        = j_ff;
      p_in        = p_ff;
      rd_valid_in = 1'b0;
      rd_slot_in  = idx_ff[SW-1:0];
      used_in     = used_ff;
      free_in     = free_ff;
      present_in  = present_ff;
      base_x_in   = base_x_ff;
      base_y_in   = base_y_ff;
      base_z_in   = base_z_ff;
      rd_en       = 1'b0;
      wr_en       = 1'b0;
      bctl        = '0;
      req_chan.ready = 1'b0;
      cmd.command    = CMD_LOAD;
      cmd.slot_index = SLOT_IDX_W'(p_ff[SW-1:0]);
      cmd.tile_x     = TILE_W'(32'(tx));
      cmd.tile_y     = TILE_W'(32'(ty));
      cmd.tile_z     = TILE_W'(32'(tz));
      case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               base_x_in = ext_x[W-1:0] - W'(VIEW_RADIUS);
               base_y_in = ext_y[W-1:0] - W'(VIEW_RADIUS);
               base_z_in = ext_z[W-1:0] - W'(VIEW_RADIUS);
               idx_in    = '0;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!idx_ff[SW]) begin
               rd_en       = 1'b1;
               rd_valid_in = 1'b1;
               idx_in      = idx_ff + 1'b1;
            end
            if (rd_valid_ff) begin
               if (used_ff[rd_slot_ff] && in_win) begin
                  present_in[hit_j] = 1'b1;
               end else begin
                  free_in[rd_slot_ff] = 1'b1;
               end
            end else if (idx_ff[SW]) begin
               j_in     = '0;
               p_in     = '0;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (j_ff[SW] || p_ff[SW]) begin
               state_in = ST_RELEASE;
            end else if (present_ff[j_ff[SW-1:0]]) begin
               j_in = j_ff + 1'b1;
            end else if (!free_ff[p_ff[SW-1:0]]) begin
               p_in = p_ff + 1'b1;
            end else if (can_take) begin
               bctl.push              = 1'b1;
               wr_en                  = 1'b1;
               used_in[p_ff[SW-1:0]]  = 1'b1;
               free_in[p_ff[SW-1:0]]  = 1'b0;
               p_in                   = p_ff + 1'b1;
               j_in                   = j_ff + 1'b1;
            end
         end
         ST_RELEASE: begin
            cmd.command = CMD_RELEASE;
            cmd.tile_x  = '0;
            cmd.tile_y  = '0;
            cmd.tile_z  = '0;
            if (p_ff[SW]) begin
               state_in = ST_FLUSH;
            end else if (!free_ff[p_ff[SW-1:0]]) begin
               p_in = p_ff + 1'b1;
            end else if (can_take) begin
               bctl.push              = 1'b1;
               used_in[p_ff[SW-1:0]]  = 1'b0;
               free_in[p_ff[SW-1:0]]  = 1'b0;
               p_in                   = p_ff + 1'b1;
            end
         end
         ST_FLUSH: begin
            if (can_take) begin
               bctl.finish = 1'b1;
               present_in  = '0;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         rd_valid_ff <= 1'b0;
         used_ff     <= '0;
         free_ff     <= '0;
         present_ff  <= '0;
      end else begin
         state_ff    <= state_in;
         rd_valid_ff <= rd_valid_in;
         used_ff     <= used_in;
         free_ff     <= free_in;
         present_ff  <= present_in;
      end
      idx_ff     <= idx_in;
      j_ff       <= j_in;
      p_ff       <= p_in;
      rd_slot_ff <= rd_slot_in;
      base_x_ff  <= base_x_in;
      base_y_ff  <= base_y_in;
      base_z_ff  <= base_z_in;
   end

   `SWSR_ASSERT_NOW(a_idle_clean, state_ff == ST_IDLE, (free_ff == '0) && (present_ff == '0))
   `SWSR_ASSERT_NEXT(a_accept_scan, req_chan.valid && req_chan.ready, state_ff == ST_SCAN)
   `SWSR_ASSERT_NOW(a_read_in_scan, rd_valid_ff, state_ff == ST_SCAN)
endmodule
`default_nettype wire

// File: design/swsr_tile_mem.sv
`default_nettype none
module swsr_tile_mem #(
   parameter int DEPTH = 64,
   parameter int AW    = 6,
   parameter int DW    = 48
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [DW-1:0] wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [DW-1:0] rd_data
);
   logic [DW-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end
endmodule
`default_nettype wire

// File: design/swsr_rsp_buf.sv
`default_nettype none
module swsr_rsp_buf
   import swsr_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire buf_ctrl_type ctrl,
   input  wire cmd_type      cmd,
   output logic              can_take,
   swsr_rsp_if.source        rsp_chan
);
   // one word held back so the final one can be tagged last
   logic    pend_valid_ff, pend_valid_in;
   cmd_type pend_ff, pend_in;
   logic    out_valid_ff, out_valid_in;
   cmd_type out_ff, out_in;
   logic    out_last_ff, out_last_in;
   logic    out_free, move;

   always_comb begin
      out_free      = !out_valid_ff || rsp_chan.ready;
      can_take      = !pend_valid_ff || out_free;
      move          = pend_valid_ff && (ctrl.push || ctrl.finish);
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      out_in        = out_ff;
      out_last_in   = out_last_ff;
      out_valid_in  = out_valid_ff && !rsp_chan.ready;
      if (move) begin
         out_in       = pend_ff;
         out_last_in  = ctrl.finish;
         out_valid_in = 1'b1;
      end
      if (ctrl.push) begin
         pend_in       = cmd;
         pend_valid_in = 1'b1;
      end else if (ctrl.finish) begin
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      pend_ff     <= pend_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.command    = out_ff.command;
   assign rsp_chan.slot_index = out_ff.slot_index;
   assign rsp_chan.tile_x     = out_ff.tile_x;
   assign rsp_chan.tile_y     = out_ff.tile_y;
   assign rsp_chan.tile_z     = out_ff.tile_z;
   assign rsp_chan.last       = out_last_ff;
endmodule
`default_nettype wire
